### src/frame_time_averager_fps_counter_core_defines.svh
// ----------------------------------------------------------------------------
// Frame time averager assertion macros
// Shared assertion helpers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef FRAME_TIME_AVERAGER_FPS_COUNTER_CORE_DEFINES_SVH
`define FRAME_TIME_AVERAGER_FPS_COUNTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Condition that must never be true outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    `ASSERT_CLK(label, !(cond), msg)
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif

`endif

### src/ftafps_pkg.sv
// ----------------------------------------------------------------------------
// ftafps_pkg
// Widths, constants and types shared by the frame time averager files.
// ----------------------------------------------------------------------------
`default_nettype none

package ftafps_pkg;

    // Field widths of the frame and result beats.
    localparam int TS_W   = 64;
    localparam int TICK_W = 32;
    localparam int RATE_W = 16;

    // Reset value of the one-second register and the frame count ceiling.
    localparam logic [TICK_W-1:0] TPS_RESET = 32'd1000;
    localparam logic [RATE_W-1:0] RATE_MAX  = 16'hFFFF;

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_CALC = 5'b00010,
        ST_LOAD = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

`default_nettype wire

### src/ftafps_if.sv
// ----------------------------------------------------------------------------
// ftafps channel interfaces
// Valid/ready channels for frame beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ftafps_in_if;
    import ftafps_pkg::*;

    logic              valid;
    logic              ready;
    logic [TS_W-1:0]   timestamp;

    modport source (output valid, output timestamp, input ready);
    modport sink   (input valid, input timestamp, output ready);
endinterface

interface ftafps_out_if;
    import ftafps_pkg::*;

    logic                valid;
    logic                ready;
    logic [TICK_W-1:0]   frame_ticks;
    logic [TICK_W-1:0]   avg_frame_ticks;
    logic [RATE_W-1:0]   frame_rate;
    logic                sample_taken;

    modport source (output valid, output frame_ticks, output avg_frame_ticks,
                    output frame_rate, output sample_taken, input ready);
    modport sink   (input valid, input frame_ticks, input avg_frame_ticks,
                    input frame_rate, input sample_taken, output ready);
endinterface

`default_nettype wire

### src/ftafps_ram.sv
// ----------------------------------------------------------------------------
// ftafps_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ftafps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable; the registered read returns the old contents in the next cycle.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

### src/ftafps_div.sv
// ----------------------------------------------------------------------------
// ftafps_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ftafps_div #(
    parameter int DIVIDEND_W = 38,
    parameter int DIVISOR_W  = 7,
    parameter int QUOT_W     = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DIVIDEND_W-1:0] dividend,
    input  wire logic [DIVISOR_W-1:0]  divisor,
    output logic                       done,
    output logic      [QUOT_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    trial_diff;
    logic                  trial_ge;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb
    begin
        trial      = {rem_reg, quo_reg[DIVIDEND_W-1]};
        trial_diff = trial - {1'b0, dsr_reg};
        trial_ge   = (trial >= {1'b0, dsr_reg});
    end

    // Step sequencing and operand capture.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = trial_ge ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], trial_ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg[QUOT_W-1:0];

endmodule

`default_nettype wire

### src/frame_time_averager_fps_counter_core.sv
// ----------------------------------------------------------------------------
// frame_time_averager_fps_counter_core
// Frame delta, moving-average frame time and frames-per-second counter.
// ----------------------------------------------------------------------------
// Usage:
// Each beat on the frame channel carries a free-running counter timestamp.
// For every frame beat the block returns exactly one result beat with the
// saturated frame delta, the moving average of the window, the latched frame
// rate and a flag that tells whether the delta entered the window.
// cfg_we/cfg_wdata set the length of one second in ticks; write it only while
// the block is idle.
// One frame is in work at a time. A result beat is valid once the frame
// has passed the update, load, divide and done states; the average is
// formed by the bit-serial divider in SUM_W = 32 + log2(WINDOW_DEPTH) steps.
// The frame channel is ready again in the cycle after the result is loaded,
// so a new frame is taken only once the last result has been loaded.
// The window lives in one RAM; a running sum is kept alongside it, so each
// frame reads a single entry and rewrites it only when the delta is taken.
// Reset clears all counters, the sum and the last timestamp; the window
// RAM is not cleared, only entries already written are ever summed.
// When the receiver stalls, the result waits in the output register and the
// next frame is still taken and worked on, but its result waits until the
// output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "frame_time_averager_fps_counter_core_defines.svh"

module frame_time_averager_fps_counter_core #(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [ftafps_pkg::TICK_W-1:0] cfg_wdata,
    ftafps_in_if.sink                        frame,
    ftafps_out_if.source                     result
);

    import ftafps_pkg::*;

    localparam int ADDR_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = TICK_W + ADDR_W;

    state_t               state_reg, state_next;
    logic [TICK_W-1:0]    tps_reg, tps_next;
    logic [TS_W-1:0]      last_stamp_reg, last_stamp_next;
    logic [ADDR_W-1:0]    wp_reg, wp_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [TICK_W-1:0]    avg_reg, avg_next;
    logic [RATE_W-1:0]    frames_reg, frames_next;
    logic [TICK_W:0]      accum_reg, accum_next;
    logic [RATE_W-1:0]    rate_reg, rate_next;
    logic [TICK_W-1:0]    delta_reg, delta_next;
    logic                 taken_reg, taken_next;
    logic                 out_valid_reg, out_valid_next;
    logic [TICK_W-1:0]    out_ticks_reg, out_ticks_next;
    logic [TICK_W-1:0]    out_avg_reg, out_avg_next;
    logic [RATE_W-1:0]    out_rate_reg, out_rate_next;
    logic                 out_taken_reg, out_taken_next;

    logic                 accept;
    logic [TS_W-1:0]      raw_delta;
    logic [TICK_W-1:0]    sat_delta;
    logic [TICK_W-1:0]    avg_diff;
    logic                 take;
    logic                 window_full;
    logic [TICK_W-1:0]    old_entry;
    logic [SUM_W:0]       sum_upd;
    logic [RATE_W-1:0]    frames_inc;
    logic [TICK_W:0]      accum_sum;
    logic                 ram_we;
    logic                 div_start;
    logic                 div_done;
    logic [TICK_W-1:0]    div_quot;
    logic                 out_load;

    // Window storage: one entry read per frame and rewritten when the delta is taken.
    ftafps_ram #(
        .WIDTH (TICK_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk   (clk),
        .we    (ram_we),
        .addr  (wp_reg),
        .wdata (delta_reg),
        .rdata (old_entry)
    );

    // Average = window sum / window count.
    ftafps_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W),
        .QUOT_W     (TICK_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

    // Frame delta as a modular difference, saturated to the tick width.
    always_comb
    begin
        accept    = frame.valid && frame.ready;
        raw_delta = frame.timestamp - last_stamp_reg;
        sat_delta = (|raw_delta[TS_W-1:TICK_W]) ? '1 : raw_delta[TICK_W-1:0];
    end

    // Window acceptance test and bookkeeping for the update cycle.
    always_comb
    begin
        avg_diff    = (delta_reg >= avg_reg) ? (delta_reg - avg_reg) : (avg_reg - delta_reg);
        take        = (avg_diff < tps_reg);
        window_full = (count_reg == CNT_W'(WINDOW_DEPTH));
        sum_upd     = {1'b0, sum_reg} + {{(SUM_W - TICK_W + 1){1'b0}}, delta_reg}
                      - {{(SUM_W - TICK_W + 1){1'b0}}, (window_full ? old_entry : '0)};
        frames_inc  = (frames_reg == RATE_MAX) ? frames_reg : frames_reg + 1'b1;
        accum_sum   = accum_reg + {1'b0, delta_reg};
        ram_we      = (state_reg == ST_CALC) && take;
        out_load    = (state_reg == ST_DONE) && (!out_valid_reg || result.ready);
    end

    // Sequencer and state updates.
    always_comb
    begin
        state_next      = state_reg;
        tps_next        = cfg_we ? cfg_wdata : tps_reg;
        last_stamp_next = last_stamp_reg;
        wp_next         = wp_reg;
        count_next      = count_reg;
        sum_next        = sum_reg;
        avg_next        = avg_reg;
        frames_next     = frames_reg;
        accum_next      = accum_reg;
        rate_next       = rate_reg;
        delta_next      = delta_reg;
        taken_next      = taken_reg;
        div_start       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    delta_next      = sat_delta;
                    last_stamp_next = frame.timestamp;
                    state_next      = ST_CALC;
                end
            end
            ST_CALC:
            begin
                taken_next = take;
                if (take)
                begin
                    sum_next = sum_upd[SUM_W-1:0];
                    wp_next  = (wp_reg == ADDR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
                    if (!window_full)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                if (accum_sum > {1'b0, tps_reg})
                begin
                    rate_next   = frames_inc;
                    frames_next = '0;
                    accum_next  = '0;
                end
                else
                begin
                    frames_next = frames_inc;
                    accum_next  = accum_sum;
                end
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                // The divider latches the updated sum and count here.
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    avg_next   = (count_reg == '0) ? '0 : div_quot;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register: holds a result until the receiver takes it.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_ticks_next = out_ticks_reg;
        out_avg_next   = out_avg_reg;
        out_rate_next  = out_rate_reg;
        out_taken_next = out_taken_reg;
        if (result.valid && result.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_ticks_next = delta_reg;
            out_avg_next   = avg_reg;
            out_rate_next  = rate_reg;
            out_taken_next = taken_reg;
        end
    end

    // Control state and counters.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tps_reg        <= TPS_RESET;
            last_stamp_reg <= '0;
            wp_reg         <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            avg_reg        <= '0;
            frames_reg     <= '0;
            accum_reg      <= '0;
            rate_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            tps_reg        <= tps_next;
            last_stamp_reg <= last_stamp_next;
            wp_reg         <= wp_next;
            count_reg      <= count_next;
            sum_reg        <= sum_next;
            avg_reg        <= avg_next;
            frames_reg     <= frames_next;
            accum_reg      <= accum_next;
            rate_reg       <= rate_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        delta_reg     <= delta_next;
        taken_reg     <= taken_next;
        out_ticks_reg <= out_ticks_next;
        out_avg_reg   <= out_avg_next;
        out_rate_reg  <= out_rate_next;
        out_taken_reg <= out_taken_next;
    end

    assign frame.ready            = (state_reg == ST_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.frame_ticks     = out_ticks_reg;
    assign result.avg_frame_ticks = out_avg_reg;
    assign result.frame_rate      = out_rate_reg;
    assign result.sample_taken    = out_taken_reg;

    // The window count never passes the window depth.
    `ASSERT_NEVER(a_count_bound, count_reg > CNT_W'(WINDOW_DEPTH), "window count above depth")
    // An accepted frame always moves straight to the update cycle.
    `ASSERT_CLK(a_accept_calc, accept |=> (state_reg == ST_CALC), "accept did not start update")
    // A result appears only when a finished frame is handed over.
    `ASSERT_CLK(a_result_src, $rose(result.valid) |-> $past(state_reg == ST_DONE), "result without frame")

endmodule

`default_nettype wire
